// ===== rtl/dlne_pkg.sv =====
package dlne_pkg;

	// fixed field widths
	localparam int PIXEL_W     = 16;
	localparam int FRAME_DIM_W = 13;
	localparam int DIVISOR_W   = 25;
	localparam int EST_W       = 16;
	localparam int CFG_DATA_W  = 25;
	localparam int CFG_INDEX_W = 2;

	// parameter defaults
	localparam int MAX_WIDTH_DEF  = 4096;
	localparam int MAX_HEIGHT_DEF = 4096;
	localparam int PIXEL_BITS_DEF = 16;

	// register reset values
	localparam logic [FRAME_DIM_W-1:0] FRAME_WIDTH_RST  = 13'd512;
	localparam logic [FRAME_DIM_W-1:0] FRAME_HEIGHT_RST = 13'd512;
	localparam logic [DIVISOR_W-1:0]   DIVISOR_RST      = 25'd1;

	// result scale of 30, applied as (x << 5) - (x << 1)
	localparam int SCALE_BITS = 5;

	localparam int NUM_BASE_DIRS = 8;
	localparam int NUM_DIRS      = 16;
	localparam int WIN_SIZE      = 9;

	// window positions of the two outer taps of each direction
	localparam logic [3:0] PAIR_A [NUM_DIRS] = '{
		4'd3, 4'd1, 4'd0, 4'd6, 4'd3, 4'd5, 4'd5, 4'd3,
		4'd3, 4'd3, 4'd5, 4'd5, 4'd1, 4'd1, 4'd7, 4'd7
	};
	localparam logic [3:0] PAIR_B [NUM_DIRS] = '{
		4'd5, 4'd7, 4'd8, 4'd2, 4'd1, 4'd1, 4'd7, 4'd7,
		4'd2, 4'd8, 4'd0, 4'd6, 4'd8, 4'd6, 4'd2, 4'd0
	};
	localparam int CENTRE = 4;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_FRAME_WIDTH,
		REG_FRAME_HEIGHT,
		REG_DIVISOR,
		REG_EXTRA_DIRECTIONS
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_DIFF,
		ST_MIN,
		ST_ACC,
		ST_DIV,
		ST_DIV_WAIT,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic capture;
		logic shift;
		logic diff;
		logic find_min;
		logic accumulate;
		logic div_start;
		logic load_result;
	} cmd_t;

	typedef struct packed {
		logic frame_end;
		logic div_done;
		logic out_free;
	} status_t;

endpackage

// ===== rtl/dlne_if.sv =====
interface dlne_pixel_if import dlne_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [PIXEL_W-1:0] pixel;

	modport source (output valid, output pixel, input ready);
	modport sink (input valid, input pixel, output ready);
endinterface

interface dlne_result_if import dlne_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [EST_W-1:0] noise_estimate;
	logic             saturated;

	modport source (output valid, output noise_estimate, output saturated, input ready);
	modport sink (input valid, input noise_estimate, input saturated, output ready);
endinterface

// ===== rtl/dlne_ram.sv =====
module dlne_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/dlne_divider.sv =====
module dlne_divider import dlne_pkg::*; #(
	parameter int DIVIDEND_W = 46
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  done,
	output logic [DIVIDEND_W-1:0] quotient
);

	localparam int CW = $clog2(DIVIDEND_W + 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CW-1:0]         cnt_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  div_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W:0]    shifted;
	logic [DIVISOR_W:0]    trial;
	logic                  neg;

	// one restoring step per cycle
	always_comb begin
		shifted = {rem_q, quo_q[DIVIDEND_W-1]};
		trial   = shifted - {1'b0, div_q};
		neg     = trial[DIVISOR_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DIVIDEND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= neg ? shifted[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
			quo_q <= {quo_q[DIVIDEND_W-2:0], ~neg};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/dlne_datapath.sv =====
module dlne_datapath import dlne_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
	parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic [PIXEL_W-1:0]     pixel,
	input  cmd_t                   cmd,
	output status_t                status,
	input  logic                   result_ready,
	output logic                   result_valid,
	output logic [EST_W-1:0]       noise_estimate,
	output logic                   saturated
);

	localparam int AW     = $clog2(MAX_WIDTH);
	localparam int RW     = $clog2(MAX_HEIGHT);
	localparam int DIFF_W = PIXEL_BITS + 2;
	localparam int ABS_W  = PIXEL_BITS + 1;
	localparam int ACC_W  = ABS_W + AW + RW;
	localparam int PROD_W = ACC_W + SCALE_BITS;

	// configuration
	logic [FRAME_DIM_W-1:0] frame_width_q;
	logic [FRAME_DIM_W-1:0] frame_height_q;
	logic [DIVISOR_W-1:0]   divisor_q;
	logic                   extra_q;

	logic [31:0]            fw_ext;
	logic [31:0]            fh_ext;
	logic [AW-1:0]          wm1;
	logic [RW-1:0]          hm1;
	logic [DIVISOR_W-1:0]   div_eff;

	// position and window
	logic [AW-1:0]          column_q;
	logic [RW-1:0]          row_q;
	logic [AW-1:0]          col;
	logic [AW-1:0]          col_q;
	logic [PIXEL_BITS-1:0]  px_q;
	logic [PIXEL_BITS-1:0]  win_q [WIN_SIZE];
	logic [PIXEL_BITS-1:0]  top_rdata;
	logic [PIXEL_BITS-1:0]  mid_rdata;

	// directions
	logic [DIFF_W-1:0]      diff_sum [NUM_DIRS];
	logic [DIFF_W-1:0]      diff_mag [NUM_DIRS];
	logic [ABS_W-1:0]       diff_abs [NUM_DIRS];
	logic [ABS_W-1:0]       abs_s1 [NUM_DIRS];
	logic [ABS_W-1:0]       lvl1 [8];
	logic [ABS_W-1:0]       lvl2 [4];
	logic [ABS_W-1:0]       lvl3 [2];
	logic [ABS_W-1:0]       min_val;
	logic [ABS_W-1:0]       min_s2;

	logic [ACC_W-1:0]       acc_q;
	logic [PROD_W-1:0]      product;
	logic                   div_done;
	logic [PROD_W-1:0]      quotient;
	logic                   quo_over;

	logic                   res_valid_q;
	logic [EST_W-1:0]       est_q;
	logic                   sat_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
			divisor_q      <= DIVISOR_RST;
			extra_q        <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_FRAME_WIDTH:      frame_width_q  <= cfg_data[FRAME_DIM_W-1:0];
				REG_FRAME_HEIGHT:     frame_height_q <= cfg_data[FRAME_DIM_W-1:0];
				REG_DIVISOR:          divisor_q      <= cfg_data[DIVISOR_W-1:0];
				REG_EXTRA_DIRECTIONS: extra_q        <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// last column and row, clamped to the supported frame
	always_comb begin
		fw_ext = 32'(frame_width_q);
		fh_ext = 32'(frame_height_q);
		if (fw_ext < 32'd3) begin
			wm1 = AW'(2);
		end else if (fw_ext > 32'(MAX_WIDTH)) begin
			wm1 = AW'(MAX_WIDTH - 1);
		end else begin
			wm1 = AW'(fw_ext - 32'd1);
		end
		if (fh_ext < 32'd3) begin
			hm1 = RW'(2);
		end else if (fh_ext > 32'(MAX_HEIGHT)) begin
			hm1 = RW'(MAX_HEIGHT - 1);
		end else begin
			hm1 = RW'(fh_ext - 32'd1);
		end
		div_eff = (divisor_q == '0) ? DIVISOR_W'(1) : divisor_q;
		col     = (column_q > wm1) ? wm1 : column_q;
	end

	// line stores: top row and middle row
	dlne_ram #(
		.WIDTH (PIXEL_BITS),
		.DEPTH (MAX_WIDTH)
	) u_top_ram (
		.clk   (clk),
		.we    (cmd.shift),
		.waddr (col_q),
		.wdata (mid_rdata),
		.raddr (col),
		.rdata (top_rdata)
	);

	dlne_ram #(
		.WIDTH (PIXEL_BITS),
		.DEPTH (MAX_WIDTH)
	) u_mid_ram (
		.clk   (clk),
		.we    (cmd.shift),
		.waddr (col_q),
		.wdata (px_q),
		.raddr (col),
		.rdata (mid_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			px_q  <= PIXEL_BITS'(pixel);
			col_q <= col;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WIN_SIZE; i++) begin
				win_q[i] <= '0;
			end
		end else if (cmd.shift) begin
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			win_q[2] <= top_rdata;
			win_q[3] <= win_q[4];
			win_q[4] <= win_q[5];
			win_q[5] <= mid_rdata;
			win_q[6] <= win_q[7];
			win_q[7] <= win_q[8];
			win_q[8] <= px_q;
		end
	end

	// second differences a + b - 2*centre, magnitudes
	always_comb begin
		for (int i = 0; i < NUM_DIRS; i++) begin
			diff_sum[i] = {2'b00, win_q[PAIR_A[i]]} + {2'b00, win_q[PAIR_B[i]]}
				- {1'b0, win_q[CENTRE], 1'b0};
			diff_mag[i] = diff_sum[i][DIFF_W-1] ? (~diff_sum[i] + DIFF_W'(1)) : diff_sum[i];
			diff_abs[i] = diff_mag[i][ABS_W-1:0];
			if (i >= NUM_BASE_DIRS && !extra_q) begin
				diff_abs[i] = '1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.diff) begin
			for (int i = 0; i < NUM_DIRS; i++) begin
				abs_s1[i] <= diff_abs[i];
			end
		end
	end

	// minimum tree over the sixteen magnitudes
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			lvl1[i] = (abs_s1[2*i] < abs_s1[2*i+1]) ? abs_s1[2*i] : abs_s1[2*i+1];
		end
		for (int i = 0; i < 4; i++) begin
			lvl2[i] = (lvl1[2*i] < lvl1[2*i+1]) ? lvl1[2*i] : lvl1[2*i+1];
		end
		for (int i = 0; i < 2; i++) begin
			lvl3[i] = (lvl2[2*i] < lvl2[2*i+1]) ? lvl2[2*i] : lvl2[2*i+1];
		end
		min_val = (lvl3[0] < lvl3[1]) ? lvl3[0] : lvl3[1];
	end

	always_ff @(posedge clk) begin
		if (cmd.find_min) begin
			min_s2 <= min_val;
		end
	end

	// accumulator and raster position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			column_q <= '0;
			row_q    <= '0;
		end else if (cmd.accumulate) begin
			if (row_q >= RW'(2) && col_q >= AW'(2)) begin
				acc_q <= acc_q + ACC_W'(min_s2);
			end
			if (col_q >= wm1) begin
				column_q <= '0;
				if (row_q >= hm1) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + RW'(1);
				end
			end else begin
				column_q <= col_q + AW'(1);
			end
		end else if (cmd.div_start) begin
			acc_q <= '0;
		end
	end

	// times thirty by shift and subtract
	assign product = (PROD_W'(acc_q) << 5) - (PROD_W'(acc_q) << 1);

	dlne_divider #(
		.DIVIDEND_W (PROD_W)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (product),
		.divisor  (div_eff),
		.done     (div_done),
		.quotient (quotient)
	);

	assign quo_over = |quotient[PROD_W-1:EST_W];

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.load_result) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			est_q <= quo_over ? '1 : quotient[EST_W-1:0];
			sat_q <= quo_over;
		end
	end

	always_comb begin
		status.frame_end = (col_q >= wm1) && (row_q >= hm1);
		status.div_done  = div_done;
		status.out_free  = !res_valid_q || result_ready;
	end

	assign result_valid   = res_valid_q;
	assign noise_estimate = est_q;
	assign saturated      = sat_q;

endmodule

// ===== rtl/dlne_ctrl.sv =====
module dlne_ctrl import dlne_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_READ;
				end
			end
			ST_READ: begin
				cmd.shift = 1'b1;
				state_d   = ST_DIFF;
			end
			ST_DIFF: begin
				cmd.diff = 1'b1;
				state_d  = ST_MIN;
			end
			ST_MIN: begin
				cmd.find_min = 1'b1;
				state_d      = ST_ACC;
			end
			ST_ACC: begin
				cmd.accumulate = 1'b1;
				state_d        = status.frame_end ? ST_DIV : ST_IDLE;
			end
			ST_DIV: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (status.div_done) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (status.out_free) begin
					cmd.load_result = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/directional_laplacian_noise_estimator.sv =====
// frame noise estimator from the minimum directional second difference
// stream: pixels of each frame in raster order, valid/ready, one transfer per pixel
// result: one transfer per frame carrying noise_estimate and saturated
// cfg_we/cfg_index/cfg_data: single-cycle register writes, change them between pixels only
// each pixel passes through accept, line store read, differences, minimum tree and
//   accumulate; the registered read of the line store RAMs and the minimum tree each add a step
// after the last pixel of a frame a restoring divider runs one bit per cycle over
//   the ACC_W + 5 bits of the scaled sum (46 at the default sizes); the result is registered
//   once the division is done and the result register is free
// a waiting result does not block the next frame's pixels; besides the division itself, only a
//   second result ready before the first was taken holds the pixel stream until the receiver drains it
// reset clears counters, window, accumulator and registers (512, 512, 1, 0);
//   the line stores are not cleared and need no clearing pass
module directional_laplacian_noise_estimator import dlne_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
	parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	dlne_pixel_if.sink             stream,
	dlne_result_if.source          result
);

	cmd_t    cmd;
	status_t status;
	logic    ready;

	// sequencer: one pixel in flight, then the frame-end division
	dlne_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (stream.valid),
		.in_ready (ready),
		.status   (status),
		.cmd      (cmd)
	);

	assign stream.ready = ready;

	// line stores, window, accumulator, divider and the result register
	dlne_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.PIXEL_BITS (PIXEL_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.pixel          (stream.pixel),
		.cmd            (cmd),
		.status         (status),
		.result_ready   (result.ready),
		.result_valid   (result.valid),
		.noise_estimate (result.noise_estimate),
		.saturated      (result.saturated)
	);

endmodule
